// File: rtl/mmrc_pkg.sv
// Shared constants, result type and CRC-16 byte fold for the meter response checker.
package mmrc_pkg;

  localparam int FRAME_BYTES    = 25;
  localparam int POS_W          = 5;
  localparam int WORD_COUNT     = 10;
  localparam int WSEL_W         = 4;
  localparam int FIRST_REG_BYTE = 3;

  localparam logic [POS_W-1:0] CRC_LO_POS  = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] FIRST_REG   = POS_W'(FIRST_REG_BYTE);
  localparam logic [15:0]      CRC_INIT    = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY    = 16'hA001;

  localparam int TDATA_W = 160;

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [15:0] frequency;
    logic [15:0] power_factor;
    logic [15:0] alarm;
  } result_t;

  // Reflected CRC-16, one byte folded in LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/modbus_meter_response_checker.sv
// Top level of the Modbus RTU energy meter response checker.
//
// The slave-side channel takes one received byte per word: in_tdata holds the byte and
// in_tuser marks the first byte of a frame. A frame is FRAME_BYTES bytes long; a start
// mark anywhere restarts the frame, and after the last byte (or reset) the next byte is
// byte 0 even without a mark. Bytes before the two CRC bytes feed a reflected CRC-16
// (poly 0xA001, init 0xFFFF); bytes 3 to 22 are captured as ten big-endian words.
// On the last byte one word leaves on the master side: out_tuser is 1 when the received
// CRC matches, out_tdata carries the measured values.
// Flow: an accepted byte is registered in the input register and is processed into the
// result register once that register can take a word, so out_tvalid rises after the
// last byte of a frame has passed both registers. One byte per cycle is sustained
// while the result register can take a word; the combinational CRC fold and the word
// capture between the two registers set that rate.
// When the receiver stalls with a result held, bytes that close no frame still move
// on only as far as the input register; the next byte is taken once the held result
// leaves. Reset clears the valid flags, the byte position and the CRC.
module modbus_meter_response_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]   in_tuser,   // [0] frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // [15:0] voltage, [47:16] current, [79:48] power,
                                   // [111:80] energy, [127:112] frequency,
                                   // [143:128] power_factor, [159:144] alarm
  output logic [0:0]   out_tuser   // [0] crc_ok
);

  logic              in_valid_r;
  logic [7:0]        byte_r;
  logic              start_r;
  logic              can_load;
  logic              step;
  logic              res_valid;
  mmrc_pkg::result_t res;

  // The staged byte moves on whenever the result register can take a word.
  assign step      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r  <= in_tdata;
      start_r <= in_tuser[0];
    end
  end

  mmrc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (byte_r),
    .frame_start (start_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  mmrc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res_valid),
    .res_in     (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/mmrc_frame.sv
// Frame tracker: byte position, running CRC, captured register words and result build.
module mmrc_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  output logic                 res_valid,
  output mmrc_pkg::result_t    res
);

  logic [mmrc_pkg::POS_W-1:0]  idx_r, idx_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [7:0]                  crc_lo_r, crc_lo_nxt;
  logic [15:0]                 words_r [mmrc_pkg::WORD_COUNT];

  logic [mmrc_pkg::POS_W-1:0]  pos;
  logic [mmrc_pkg::POS_W-1:0]  off;
  logic [mmrc_pkg::WSEL_W-1:0] wsel;
  logic [15:0]                 crc_base;
  logic                        cap_en;

  always_comb begin
    pos      = frame_start ? '0 : idx_r;
    crc_base = (pos == '0) ? mmrc_pkg::CRC_INIT : crc_r;
    off      = pos - mmrc_pkg::FIRST_REG;
    wsel     = off[mmrc_pkg::POS_W-1:1];
    cap_en   = 1'b0;
    res_valid  = 1'b0;
    crc_lo_nxt = crc_lo_r;
    if (pos < mmrc_pkg::CRC_LO_POS) begin
      crc_nxt = mmrc_pkg::crc_fold(crc_base, rx_byte);
      idx_nxt = pos + 1'b1;
      cap_en  = (pos >= mmrc_pkg::FIRST_REG) &&
                (wsel < mmrc_pkg::WSEL_W'(mmrc_pkg::WORD_COUNT));
    end else if (pos == mmrc_pkg::CRC_LO_POS) begin
      crc_nxt    = crc_base;
      crc_lo_nxt = rx_byte;
      idx_nxt    = pos + 1'b1;
    end else begin
      // CRC high byte closes the frame.
      crc_nxt   = mmrc_pkg::CRC_INIT;
      idx_nxt   = '0;
      res_valid = 1'b1;
    end

    res.crc_ok       = (crc_lo_r == crc_base[7:0]) && (rx_byte == crc_base[15:8]);
    res.voltage      = words_r[0];
    res.current      = {words_r[2], words_r[1]};
    res.power        = {words_r[4], words_r[3]};
    res.energy       = {words_r[6], words_r[5]};
    res.frequency    = words_r[7];
    res.power_factor = words_r[8];
    res.alarm        = words_r[9];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      crc_r    <= mmrc_pkg::CRC_INIT;
      crc_lo_r <= '0;
    end else if (step) begin
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // Big-endian words: even offset carries the high byte.
  always_ff @(posedge clk) begin
    if (step && cap_en) begin
      if (!off[0]) begin
        words_r[wsel][15:8] <= rx_byte;
      end else begin
        words_r[wsel][7:0] <= rx_byte;
      end
    end
  end

endmodule

// File: rtl/mmrc_out_reg.sv
// Result register driving the master-side stream channel.
module mmrc_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  mmrc_pkg::result_t             res_in,
  output logic                          can_load,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mmrc_pkg::TDATA_W-1:0]  out_tdata,
  output logic [0:0]                    out_tuser
);

  logic              valid_r;
  mmrc_pkg::result_t res_r;

  assign can_load   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.alarm, res_r.power_factor, res_r.frequency, res_r.energy,
                       res_r.power, res_r.current, res_r.voltage};
  assign out_tuser  = res_r.crc_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: test/modbus_meter_response_checker_tb.sv
`timescale 1ns / 100ps
// Testbench for the Modbus meter response checker: frame stimulus, a byte-level model, checks.
module modbus_meter_response_checker_tb;

  // Frame layout as seen on the wire.
  localparam int NBYTES    = mmrc_pkg::FRAME_BYTES;
  localparam int CRC_LO_AT = NBYTES - 2;
  localparam int CRC_HI_AT = NBYTES - 1;
  localparam int REG_FIRST = 3;
  localparam int REG_LAST  = 22;
  localparam int NWORDS    = 10;

  localparam logic [15:0] SEED_CRC  = 16'hFFFF;
  localparam logic [15:0] POLY_REFL = 16'hA001;
  localparam logic [7:0]  MB_ADDR   = 8'h01;
  localparam logic [7:0]  MB_FUNC   = 8'h04;
  localparam logic [7:0]  MB_COUNT  = 8'h14;

  localparam int RANDOM_BYTES = 1290;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_MIXED} fill_t;
  typedef enum {CRC_GOOD, CRC_BAD_LOW, CRC_BAD_HIGH, CRC_BAD_BOTH} crc_damage_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_pace_t;

  // Reflected CRC-16, one byte folded in, least significant bit first.
  function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ POLY_REFL) : (c >> 1);
    return c;
  endfunction

  // Byte-level model of the checker plus the queue of readings it predicts.
  class meter_frame_model;
    logic [15:0] crc;
    logic [4:0]  pos;
    logic [15:0] words[NWORDS];
    logic [7:0]  crc_lo;
    mmrc_pkg::result_t readings[$];
    int errors;

    function new();
      crc    = SEED_CRC;
      pos    = '0;
      crc_lo = '0;
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // Called for every word accepted on the input side.
    function void take_byte(logic [7:0] b, logic mark);
      int off;
      mmrc_pkg::result_t r;
      if (mark) pos = '0;
      if (pos == 0) crc = SEED_CRC;
      if (pos < CRC_LO_AT) begin
        crc = crc16_byte(crc, b);
        if (pos >= REG_FIRST && pos <= REG_LAST) begin
          off = pos - REG_FIRST;
          if (off[0]) begin
            words[off >> 1][7:0] = b;
          end else begin
            words[off >> 1][15:8] = b;
          end
        end
        pos = 5'(pos + 1);
      end else if (pos == CRC_LO_AT) begin
        crc_lo = b;
        pos = 5'(pos + 1);
      end else begin
        r.crc_ok       = (crc_lo == crc[7:0]) && (b == crc[15:8]);
        r.voltage      = words[0];
        r.current      = {words[2], words[1]};
        r.power        = {words[4], words[3]};
        r.energy       = {words[6], words[5]};
        r.frequency    = words[7];
        r.power_factor = words[8];
        r.alarm        = words[9];
        readings.push_back(r);
        pos = '0;
        crc = SEED_CRC;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // Called for every word accepted on the output side.
    function void compare_reading(mmrc_pkg::result_t got);
      mmrc_pkg::result_t want;
      if (readings.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected, expected nothing, got %h", $time, got);
        return;
      end
      want = readings.pop_front();
      check_field("crc_ok", want.crc_ok, got.crc_ok);
      check_field("voltage", want.voltage, got.voltage);
      check_field("current", want.current, got.current);
      check_field("power", want.power, got.power);
      check_field("energy", want.energy, got.energy);
      check_field("frequency", want.frequency, got.frequency);
      check_field("power_factor", want.power_factor, got.power_factor);
      check_field("alarm", want.alarm, got.alarm);
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;  // [7:0] rx_byte
  logic [0:0]   in_tuser   = '0;  // [0] frame_start
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;        // voltage, current, power, energy, frequency, pf, alarm
  logic [0:0]   out_tuser;        // [0] crc_ok

  meter_frame_model model = new();

  logic [7:0] frame_buf[NBYTES];
  int  bytes_sent   = 0;
  int  burst_left   = 0;
  bit  hold_off_req = 1'b0;

  modbus_meter_response_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Both channels are observed at the rising edge, with the values the block itself sees.
  always @(posedge clk) begin : watch
    mmrc_pkg::result_t seen;
    if (rst_n && in_tvalid && in_tready) begin
      model.take_byte(in_tdata, in_tuser[0]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen.crc_ok       = out_tuser[0];
      seen.voltage      = out_tdata[15:0];
      seen.current      = out_tdata[47:16];
      seen.power        = out_tdata[79:48];
      seen.energy       = out_tdata[111:80];
      seen.frequency    = out_tdata[127:112];
      seen.power_factor = out_tdata[143:128];
      seen.alarm        = out_tdata[159:144];
      model.compare_reading(seen);
    end
  end

  // Offers one byte and returns at the falling edge after it was taken. The sender runs
  // in bursts; between bursts it drops tvalid for a random gap, so gaps land anywhere
  // inside a frame.
  task automatic push_byte(logic [7:0] b, logic mark);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mark;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Fills frame_buf with a response frame and its CRC, optionally damaged.
  function automatic void build_frame(fill_t fill, bit std_header, crc_damage_t dmg);
    logic [15:0] c;
    logic [15:0] w;
    if (std_header) begin
      frame_buf[0] = MB_ADDR;
      frame_buf[1] = MB_FUNC;
      frame_buf[2] = MB_COUNT;
    end else begin
      for (int i = 0; i < REG_FIRST; i++) frame_buf[i] = 8'($urandom);
    end
    for (int i = 0; i < NWORDS; i++) begin
      case (fill)
        FILL_ZERO: w = 16'h0000;
        FILL_ONES: w = 16'hFFFF;
        default: begin
          case ($urandom_range(0, 5))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            default: w = 16'($urandom);
          endcase
        end
      endcase
      frame_buf[REG_FIRST + 2*i]     = w[15:8];
      frame_buf[REG_FIRST + 2*i + 1] = w[7:0];
    end
    // Bytes past the register block (only present in longer frames) feed the CRC only.
    for (int i = REG_LAST + 1; i < CRC_LO_AT; i++) frame_buf[i] = 8'($urandom);
    c = SEED_CRC;
    for (int i = 0; i < CRC_LO_AT; i++) c = crc16_byte(c, frame_buf[i]);
    frame_buf[CRC_LO_AT] = c[7:0];
    frame_buf[CRC_HI_AT] = c[15:8];
    if (dmg == CRC_BAD_LOW || dmg == CRC_BAD_BOTH) begin
      frame_buf[CRC_LO_AT] ^= 8'($urandom_range(1, 255));
    end
    if (dmg == CRC_BAD_HIGH || dmg == CRC_BAD_BOTH) begin
      frame_buf[CRC_HI_AT] ^= 8'($urandom_range(1, 255));
    end
  endfunction

  // Sends the first count bytes of frame_buf; mark sets the start flag on byte 0.
  task automatic send_bytes(int count, bit mark);
    for (int i = 0; i < count; i++) push_byte(frame_buf[i], mark && i == 0);
  endtask

  // Receiver: changes its pace at random intervals, and once holds off for a long
  // stretch so the block fills up and pushes back on the sender.
  initial begin : receiver
    rx_pace_t pace;
    int left;
    pace = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          pace = rx_pace_t'($urandom_range(0, 3));
          left = $urandom_range(20, 80);
        end
        left--;
        case (pace)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 4) == 0);
          default:   out_tready <= ~out_tready;
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int  start_count;
    int  pick;
    bit  must_mark;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames. The first has no start flag: after reset byte 0 needs none.
    build_frame(FILL_ZERO, 1'b1, CRC_GOOD);
    send_bytes(NBYTES, 1'b0);
    // All ones in every register, alarm on.
    build_frame(FILL_ONES, 1'b1, CRC_GOOD);
    send_bytes(NBYTES, 1'b1);
    // Straight after a complete frame, again unflagged, with odd header and bad CRC low.
    build_frame(FILL_MIXED, 1'b0, CRC_BAD_LOW);
    send_bytes(NBYTES, 1'b0);
    build_frame(FILL_MIXED, 1'b1, CRC_BAD_HIGH);
    send_bytes(NBYTES, 1'b1);
    build_frame(FILL_MIXED, 1'b1, CRC_BAD_BOTH);
    send_bytes(NBYTES, 1'b1);
    // Restart in the middle of the register block.
    build_frame(FILL_MIXED, 1'b1, CRC_GOOD);
    send_bytes(10, 1'b1);
    build_frame(FILL_ONES, 1'b1, CRC_GOOD);
    send_bytes(NBYTES, 1'b1);
    // Restart landing on the CRC low byte, then on the CRC high byte.
    build_frame(FILL_MIXED, 1'b1, CRC_GOOD);
    send_bytes(CRC_LO_AT, 1'b1);
    build_frame(FILL_MIXED, 1'b1, CRC_GOOD);
    send_bytes(NBYTES, 1'b1);
    build_frame(FILL_MIXED, 1'b1, CRC_GOOD);
    send_bytes(CRC_HI_AT, 1'b1);
    build_frame(FILL_ZERO, 1'b1, CRC_GOOD);
    send_bytes(NBYTES, 1'b1);

    // Random part: mostly whole frames, some with a broken CRC, some cut short, some noise.
    hold_off_req = 1'b1;
    start_count = bytes_sent;
    must_mark = 1'b0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_frame(FILL_MIXED, $urandom_range(0, 7) != 0, CRC_GOOD);
        send_bytes(NBYTES, must_mark || $urandom_range(0, 3) != 0);
        must_mark = 1'b0;
      end else if (pick < 80) begin
        build_frame(FILL_MIXED, 1'b1, crc_damage_t'($urandom_range(1, 3)));
        send_bytes(NBYTES, 1'b1);
        must_mark = 1'b0;
      end else if (pick < 90) begin
        build_frame(FILL_MIXED, 1'b1, CRC_GOOD);
        send_bytes($urandom_range(1, CRC_HI_AT), 1'b1);
        must_mark = 1'b1;
      end else begin
        repeat ($urandom_range(1, 30)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
        must_mark = 1'b1;
      end
    end
    in_tvalid <= 1'b0;

    // Drain: every predicted reading must come out, then nothing more may follow.
    while (model.readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: modbus_meter_response_checker.f
rtl/mmrc_pkg.sv
rtl/mmrc_frame.sv
rtl/mmrc_out_reg.sv
rtl/modbus_meter_response_checker.sv
test/modbus_meter_response_checker_tb.sv
